FILE: design/fpa_pkg.sv
// Package for the Q24.8 fixed-point ALU: opcodes and status codes.
package fpa_pkg;

    // Operation codes carried in the low bits of the input beat
    typedef enum logic [3:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_GT   = 4'd4,
        OP_LT   = 4'd5,
        OP_GE   = 4'd6,
        OP_LE   = 4'd7,
        OP_EQ   = 4'd8,
        OP_NE   = 4'd9,
        OP_MIN  = 4'd10,
        OP_MAX  = 4'd11,
        OP_INC  = 4'd12,
        OP_DEC  = 4'd13,
        OP_FINT = 4'd14,
        OP_TINT = 4'd15
    } t_op;

    // Result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OVF  = 2'd1;
    localparam logic [1:0] ST_DIVZ = 2'd2;

endpackage

FILE: design/fixed_point_q24_8_alu.sv
// Signed fixed-point ALU with a fully pipelined restoring divider.
//
// Every input beat carries an opcode and two signed 32-bit raw fixed-point
// operands; every beat yields exactly one result beat, in order. One beat can
// enter each cycle while the output beat is not stalled. Each beat passes
// through 4 + 32 + FRAC_BITS register stages: one input stage, one operand
// prepare stage, one 32x32 multiply stage, one restoring divider stage per
// quotient bit (32 + FRAC_BITS of them) and one rounding and saturation stage.
// The whole pipeline advances together and holds while the output beat is
// stalled. Multiply and divide round half away from zero; overflow saturates
// with status 1, divide by zero saturates by the dividend's sign (zero for a
// zero dividend) with status 2.
module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: [3:0] op, [35:4] operand_a, [67:36] operand_b, [71:68] zero
    input  logic [71:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: [31:0] value, [32] compare_true, [34:33] status, [39:35] zero
    output logic [39:0] o_m_tdata
);

    localparam int W = 32 + FRAC_BITS;

    typedef struct packed {
        fpa_pkg::t_op     op;
        logic             a_pos;
        logic             a_neg;
        logic             b_zero;
        logic             neg;
        logic [31:0]      ma;
        logic [31:0]      mb;
        logic [31:0]      value;
        logic             cmp;
        logic [1:0]       st;
        logic [63:0]      prod;
        logic [W-1:0]     num;
        logic [31:0]      rem;
        logic [W-1:0]     quo;
    } t_stg;

    // Apply a sign to a magnitude and saturate to 32 signed bits
    function automatic logic [33:0] sat_mag(input logic [63:0] mag, input logic neg);
        logic [33:0] res;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) res = {fpa_pkg::ST_OVF, 32'h8000_0000};
            else res = {fpa_pkg::ST_OK, 32'(64'd0 - mag)};
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) res = {fpa_pkg::ST_OVF, 32'h7FFF_FFFF};
            else res = {fpa_pkg::ST_OK, mag[31:0]};
        end
        return res;
    endfunction

    logic en;

    // Input stage
    logic               r_v1;
    fpa_pkg::t_op       r_op1;
    logic signed [31:0] r_a1;
    logic signed [31:0] r_b1;

    // Prepare, multiply and divider stages
    logic         r_v2, r_v3;
    t_stg         r_s2, r_s3, n_s2, n_s3, seed;
    logic [W-1:0] r_vd;
    t_stg         r_dv [W];
    t_stg         n_dv [W];

    // Output stage
    logic        r_vo;
    logic [31:0] r_val_o, n_val_o;
    logic        r_cmp_o, n_cmp_o;
    logic [1:0]  r_st_o, n_st_o;

    // Advance the whole pipeline unless the output beat is stalled
    assign en         = !r_vo || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {5'd0, r_st_o, r_cmp_o, r_val_o};

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vd <= '0;
            r_vo <= 1'b0;
        end else if (en) begin
            r_v1 <= i_s_tvalid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_vd <= {r_vd[W-2:0], r_v3};
            r_vo <= r_vd[W-1];
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op1   <= fpa_pkg::t_op'(i_s_tdata[3:0]);
            r_a1    <= i_s_tdata[35:4];
            r_b1    <= i_s_tdata[67:36];
            r_s2    <= n_s2;
            r_s3    <= n_s3;
            r_val_o <= n_val_o;
            r_cmp_o <= n_cmp_o;
            r_st_o  <= n_st_o;
        end
    end

    // Prepare magnitudes and resolve the operations that need no multiply or divide
    always_comb begin
        logic signed [32:0] s;
        logic [W-1:0]       fi;
        logic signed [31:0] ti;
        n_s2        = '0;
        n_s2.op     = r_op1;
        n_s2.a_pos  = !r_a1[31] && (r_a1 != 32'sd0);
        n_s2.a_neg  = r_a1[31];
        n_s2.b_zero = (r_b1 == 32'sd0);
        n_s2.neg    = r_a1[31] ^ r_b1[31];
        n_s2.ma     = r_a1[31] ? 32'(-r_a1) : r_a1;
        n_s2.mb     = r_b1[31] ? 32'(-r_b1) : r_b1;
        n_s2.st     = fpa_pkg::ST_OK;
        s  = '0;
        fi = {r_a1, {FRAC_BITS{1'b0}}};
        ti = (r_a1 >>> FRAC_BITS) + ((r_a1[31] && (r_a1[FRAC_BITS-1:0] != '0)) ? 32'sd1 : 32'sd0);
        unique case (r_op1)
            fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
                unique case (r_op1)
                    fpa_pkg::OP_ADD: s = 33'(r_a1) + 33'(r_b1);
                    fpa_pkg::OP_SUB: s = 33'(r_a1) - 33'(r_b1);
                    fpa_pkg::OP_INC: s = 33'(r_a1) + 33'sd1;
                    default:         s = 33'(r_a1) - 33'sd1;
                endcase
                if (s[32] != s[31]) begin
                    n_s2.st    = fpa_pkg::ST_OVF;
                    n_s2.value = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n_s2.value = s[31:0];
                end
            end
            fpa_pkg::OP_GT:  n_s2.cmp = r_a1 > r_b1;
            fpa_pkg::OP_LT:  n_s2.cmp = r_a1 < r_b1;
            fpa_pkg::OP_GE:  n_s2.cmp = r_a1 >= r_b1;
            fpa_pkg::OP_LE:  n_s2.cmp = r_a1 <= r_b1;
            fpa_pkg::OP_EQ:  n_s2.cmp = r_a1 == r_b1;
            fpa_pkg::OP_NE:  n_s2.cmp = r_a1 != r_b1;
            fpa_pkg::OP_MIN: n_s2.value = (r_a1 < r_b1) ? r_a1 : r_b1;
            fpa_pkg::OP_MAX: n_s2.value = (r_a1 > r_b1) ? r_a1 : r_b1;
            fpa_pkg::OP_FINT: begin
                if (fi[W-1:31] != {(FRAC_BITS+1){fi[W-1]}}) begin
                    n_s2.st    = fpa_pkg::ST_OVF;
                    n_s2.value = fi[W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                end else begin
                    n_s2.value = fi[31:0];
                end
            end
            fpa_pkg::OP_TINT: n_s2.value = ti;
            default: ;
        endcase
    end

    // Form the magnitude product
    always_comb begin
        n_s3      = r_s2;
        n_s3.prod = 64'(r_s2.ma) * 64'(r_s2.mb);
    end

    // Finish the multiply and seed the divider
    always_comb begin
        logic [63:0] mq;
        logic [33:0] sm;
        seed     = r_s3;
        seed.num = {r_s3.ma, {FRAC_BITS{1'b0}}};
        seed.rem = '0;
        seed.quo = '0;
        mq = (r_s3.prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        sm = sat_mag(mq, r_s3.neg);
        if (r_s3.op == fpa_pkg::OP_MUL) begin
            seed.st    = sm[33:32];
            seed.value = sm[31:0];
        end
    end

    // Divider: one restoring step per stage
    for (genvar k = 0; k < W; k++) begin : g_div
        always_comb begin
            t_stg        src;
            logic [32:0] sh;
            logic [32:0] df;
            src = (k == 0) ? seed : r_dv[(k == 0) ? 0 : k-1];
            sh  = {src.rem, src.num[W-1]};
            df  = sh - {1'b0, src.mb};
            n_dv[k]     = src;
            n_dv[k].num = src.num << 1;
            if (!df[32]) begin
                n_dv[k].rem = df[31:0];
                n_dv[k].quo = {src.quo[W-2:0], 1'b1};
            end else begin
                n_dv[k].rem = sh[31:0];
                n_dv[k].quo = {src.quo[W-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv[k] <= n_dv[k];
            end
        end
    end

    // Round and saturate the quotient, select the result
    always_comb begin
        t_stg        d;
        logic        rnd;
        logic [33:0] sq;
        d   = r_dv[W-1];
        rnd = ({d.rem, 1'b0} >= {1'b0, d.mb});
        sq  = sat_mag(64'(d.quo) + 64'(rnd), d.neg);
        n_val_o = d.value;
        n_cmp_o = d.cmp;
        n_st_o  = d.st;
        if (d.op == fpa_pkg::OP_DIV) begin
            if (d.b_zero) begin
                n_st_o  = fpa_pkg::ST_DIVZ;
                n_val_o = d.a_pos ? 32'h7FFF_FFFF : (d.a_neg ? 32'h8000_0000 : 32'h0);
            end else begin
                n_st_o  = sq[33:32];
                n_val_o = sq[31:0];
            end
        end
    end

endmodule
